// File: rtl/core/sdt_pkg.sv
// Shared types and codes for the sorted deque table: commands, status codes, control words.
`default_nettype none
package sdt_pkg;

   localparam int KEY_W   = 32;
   localparam int PAY_W   = 32;
   localparam int ENTRY_W = KEY_W + PAY_W;
   localparam int CNT_W   = 5;

   localparam logic [2:0] CMD_INSERT     = 3'd0;
   localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
   localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [2:0] CMD_POP_BACK   = 3'd4;
   localparam logic [2:0] CMD_SEARCH     = 3'd5;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef enum logic [2:0] {
      RD_LAST,
      RD_ZERO,
      RD_ONE,
      RD_IDX_P1,
      RD_IDX_P2,
      RD_IDX_M1
   } rd_sel_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_ONE,
      IDX_INC,
      IDX_DEC,
      IDX_LAST
   } idx_op_type;

   typedef enum logic [1:0] {
      POS_HOLD,
      POS_ZERO,
      POS_OCC,
      POS_IDX
   } pos_op_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_ITEM,
      WR_UP,
      WR_DN
   } wr_op_type;

   typedef enum logic [1:0] {
      OCC_HOLD,
      OCC_INC,
      OCC_DEC
   } occ_op_type;

   typedef struct packed {
      logic       load_item;
      rd_sel_type rd_sel;
      idx_op_type idx_op;
      pos_op_type pos_op;
      wr_op_type  wr_op;
      occ_op_type occ_op;
      logic       set_status;
      logic [1:0] status;
      logic       load_found;
      logic       load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       occ_zero;
      logic       occ_one;
      logic       occ_full;
      logic       key_ge_rd;
      logic       key_le_rd;
      logic       key_eq_rd;
      logic       idx_at_last;
      logic       idx_p1_at_last;
      logic       idx_eq_pos;
   } dp_sts_type;

endpackage
`default_nettype wire

// File: rtl/core/sdt_datapath.sv
// Datapath: entry memory, scan index, insert position, occupancy and result word.
`default_nettype none
module sdt_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [2:0]               in_command,
   input  wire logic [sdt_pkg::KEY_W-1:0] in_key,
   input  wire logic [sdt_pkg::PAY_W-1:0] in_payload,
   input  wire sdt_pkg::ctl_cmd_type     ctl,
   output sdt_pkg::dp_sts_type           sts,
   output logic [1:0]                    rsp_status,
   output logic [sdt_pkg::KEY_W-1:0]     rsp_found_key,
   output logic [sdt_pkg::PAY_W-1:0]     rsp_found_payload,
   output logic [sdt_pkg::CNT_W-1:0]     rsp_entry_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [sdt_pkg::ENTRY_W-1:0] mem [DEPTH];
   logic [sdt_pkg::ENTRY_W-1:0] rd_data_ff;

   logic [2:0]                 cmd_ff;
   logic [sdt_pkg::KEY_W-1:0]  key_ff;
   logic [sdt_pkg::PAY_W-1:0]  pay_ff;
   logic [CW-1:0]              occ_ff, occ_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic [AW-1:0]              pos_ff, pos_in;
   logic [1:0]                 status_ff, status_in;
   logic [sdt_pkg::KEY_W-1:0]  fk_ff, fk_in;
   logic [sdt_pkg::PAY_W-1:0]  fp_ff, fp_in;

   logic [1:0]                 rsp_status_ff;
   logic [sdt_pkg::KEY_W-1:0]  rsp_fk_ff;
   logic [sdt_pkg::PAY_W-1:0]  rsp_fp_ff;
   logic [sdt_pkg::CNT_W-1:0]  rsp_cnt_ff;

   logic [CW-1:0]              occ_m1;
   logic [CW-1:0]              idx_w;
   logic [AW-1:0]              rd_addr;
   logic [AW-1:0]              wr_addr;
   logic [sdt_pkg::ENTRY_W-1:0] wr_data;
   logic                       wr_en;
   logic signed [sdt_pkg::KEY_W-1:0] rd_key;
   logic [CW+sdt_pkg::CNT_W-1:0] occ_ext;

   assign occ_m1  = occ_ff - CW'(1);
   assign idx_w   = CW'(idx_ff);
   assign rd_key  = rd_data_ff[sdt_pkg::KEY_W-1:0];
   assign occ_ext = (CW + sdt_pkg::CNT_W)'(occ_ff);

   always_comb begin
      case (ctl.rd_sel)
         sdt_pkg::RD_LAST:   rd_addr = occ_m1[AW-1:0];
         sdt_pkg::RD_ZERO:   rd_addr = '0;
         sdt_pkg::RD_ONE:    rd_addr = AW'(1);
         sdt_pkg::RD_IDX_P1: rd_addr = idx_ff + AW'(1);
         sdt_pkg::RD_IDX_P2: rd_addr = idx_ff + AW'(2);
         sdt_pkg::RD_IDX_M1: rd_addr = idx_ff - AW'(1);
         default:            rd_addr = '0;
      endcase
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff;
      wr_data = rd_data_ff;
      case (ctl.wr_op)
         sdt_pkg::WR_ITEM: begin
            wr_addr = pos_ff;
            wr_data = {pay_ff, key_ff};
         end
         sdt_pkg::WR_UP:   wr_addr = idx_ff + AW'(1);
         sdt_pkg::WR_DN:   wr_addr = idx_ff;
         default:          wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      case (ctl.idx_op)
         sdt_pkg::IDX_ZERO: idx_in = '0;
         sdt_pkg::IDX_ONE:  idx_in = AW'(1);
         sdt_pkg::IDX_INC:  idx_in = idx_ff + AW'(1);
         sdt_pkg::IDX_DEC:  idx_in = idx_ff - AW'(1);
         sdt_pkg::IDX_LAST: idx_in = occ_m1[AW-1:0];
         default:           idx_in = idx_ff;
      endcase

      case (ctl.pos_op)
         sdt_pkg::POS_ZERO: pos_in = '0;
         sdt_pkg::POS_OCC:  pos_in = occ_ff[AW-1:0];
         sdt_pkg::POS_IDX:  pos_in = idx_ff;
         default:           pos_in = pos_ff;
      endcase

      case (ctl.occ_op)
         sdt_pkg::OCC_INC: occ_in = occ_ff + CW'(1);
         sdt_pkg::OCC_DEC: occ_in = occ_m1;
         default:          occ_in = occ_ff;
      endcase

      status_in = status_ff;
      fk_in     = fk_ff;
      fp_in     = fp_ff;
      if (ctl.load_item) begin
         status_in = sdt_pkg::ST_DONE;
         fk_in     = '0;
         fp_in     = '0;
      end
      if (ctl.set_status) begin
         status_in = ctl.status;
      end
      if (ctl.load_found) begin
         fk_in = rd_data_ff[sdt_pkg::KEY_W-1:0];
         fp_in = rd_data_ff[sdt_pkg::ENTRY_W-1:sdt_pkg::KEY_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      fk_ff     <= fk_in;
      fp_ff     <= fp_in;
      if (ctl.load_item) begin
         cmd_ff <= in_command;
         key_ff <= in_key;
         pay_ff <= in_payload;
      end
      if (ctl.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_fk_ff     <= fk_ff;
         rsp_fp_ff     <= fp_ff;
         rsp_cnt_ff    <= occ_ext[sdt_pkg::CNT_W-1:0];
      end
   end

   always_comb begin
      sts.cmd            = cmd_ff;
      sts.occ_zero       = (occ_ff == '0);
      sts.occ_one        = (occ_ff == CW'(1));
      sts.occ_full       = (occ_ff >= CW'(DEPTH));
      sts.key_ge_rd      = ($signed(key_ff) >= rd_key);
      sts.key_le_rd      = ($signed(key_ff) <= rd_key);
      sts.key_eq_rd      = ($signed(key_ff) == rd_key);
      sts.idx_at_last    = (idx_w == occ_m1);
      sts.idx_p1_at_last = ((idx_w + CW'(1)) == occ_m1);
      sts.idx_eq_pos     = (idx_ff == pos_ff);
   end

   assign rsp_status        = rsp_status_ff;
   assign rsp_found_key     = rsp_fk_ff;
   assign rsp_found_payload = rsp_fp_ff;
   assign rsp_entry_count   = rsp_cnt_ff;

endmodule
`default_nettype wire

// File: rtl/core/sdt_controller.sv
// Controller: command sequencer for lookups, shifts and result hand-off.
`default_nettype none
module sdt_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire sdt_pkg::dp_sts_type sts,
   output sdt_pkg::ctl_cmd_type     ctl
);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_DECIDE    = 10'b00_0000_0010,
      S_CHK_LAST  = 10'b00_0000_0100,
      S_CHK_FIRST = 10'b00_0000_1000,
      S_SCAN_INS  = 10'b00_0001_0000,
      S_SHIFT_UP  = 10'b00_0010_0000,
      S_SHIFT_DN  = 10'b00_0100_0000,
      S_SEARCH    = 10'b00_1000_0000,
      S_WRITE     = 10'b01_0000_0000,
      S_FINISH    = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      ctl.load_item  = 1'b0;
      ctl.rd_sel     = sdt_pkg::RD_ZERO;
      ctl.idx_op     = sdt_pkg::IDX_HOLD;
      ctl.pos_op     = sdt_pkg::POS_HOLD;
      ctl.wr_op      = sdt_pkg::WR_NONE;
      ctl.occ_op     = sdt_pkg::OCC_HOLD;
      ctl.set_status = 1'b0;
      ctl.status     = sdt_pkg::ST_DONE;
      ctl.load_found = 1'b0;
      ctl.load_rsp   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load_item = 1'b1;
               state_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (sts.cmd)
               sdt_pkg::CMD_INSERT, sdt_pkg::CMD_PUSH_FRONT, sdt_pkg::CMD_PUSH_BACK: begin
                  if (sts.occ_full) begin
                     ctl.set_status = 1'b1;
                     ctl.status     = sdt_pkg::ST_FULL;
                     state_in       = S_FINISH;
                  end else if (sts.cmd == sdt_pkg::CMD_PUSH_FRONT) begin
                     ctl.pos_op = sdt_pkg::POS_ZERO;
                     if (sts.occ_zero) begin
                        state_in = S_WRITE;
                     end else begin
                        ctl.idx_op = sdt_pkg::IDX_LAST;
                        ctl.rd_sel = sdt_pkg::RD_LAST;
                        state_in   = S_SHIFT_UP;
                     end
                  end else if (sts.cmd == sdt_pkg::CMD_PUSH_BACK || sts.occ_zero) begin
                     ctl.pos_op = sdt_pkg::POS_OCC;
                     state_in   = S_WRITE;
                  end else begin
                     ctl.rd_sel = sdt_pkg::RD_LAST;
                     state_in   = S_CHK_LAST;
                  end
               end
               sdt_pkg::CMD_POP_FRONT, sdt_pkg::CMD_POP_BACK, sdt_pkg::CMD_SEARCH: begin
                  if (sts.occ_zero) begin
                     ctl.set_status = 1'b1;
                     ctl.status     = sdt_pkg::ST_EMPTY;
                     state_in       = S_FINISH;
                  end else if (sts.cmd == sdt_pkg::CMD_POP_BACK || sts.occ_one &&
                               sts.cmd == sdt_pkg::CMD_POP_FRONT) begin
                     ctl.occ_op = sdt_pkg::OCC_DEC;
                     state_in   = S_FINISH;
                  end else if (sts.cmd == sdt_pkg::CMD_POP_FRONT) begin
                     ctl.idx_op = sdt_pkg::IDX_ZERO;
                     ctl.rd_sel = sdt_pkg::RD_ONE;
                     state_in   = S_SHIFT_DN;
                  end else begin
                     ctl.idx_op = sdt_pkg::IDX_ZERO;
                     ctl.rd_sel = sdt_pkg::RD_ZERO;
                     state_in   = S_SEARCH;
                  end
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_CHK_LAST: begin
            if (sts.key_ge_rd) begin
               ctl.pos_op = sdt_pkg::POS_OCC;
               state_in   = S_WRITE;
            end else begin
               ctl.rd_sel = sdt_pkg::RD_ZERO;
               state_in   = S_CHK_FIRST;
            end
         end
         S_CHK_FIRST: begin
            if (sts.key_le_rd) begin
               ctl.pos_op = sdt_pkg::POS_ZERO;
               ctl.idx_op = sdt_pkg::IDX_LAST;
               ctl.rd_sel = sdt_pkg::RD_LAST;
               state_in   = S_SHIFT_UP;
            end else begin
               ctl.idx_op = sdt_pkg::IDX_ONE;
               ctl.rd_sel = sdt_pkg::RD_ONE;
               state_in   = S_SCAN_INS;
            end
         end
         S_SCAN_INS: begin
            // the scan stops at the last slot even without an entry key at or above the new key
            if (sts.idx_at_last || sts.key_le_rd) begin
               ctl.pos_op = sdt_pkg::POS_IDX;
               ctl.idx_op = sdt_pkg::IDX_LAST;
               ctl.rd_sel = sdt_pkg::RD_LAST;
               state_in   = S_SHIFT_UP;
            end else begin
               ctl.idx_op = sdt_pkg::IDX_INC;
               ctl.rd_sel = sdt_pkg::RD_IDX_P1;
            end
         end
         S_SHIFT_UP: begin
            ctl.wr_op = sdt_pkg::WR_UP;
            if (sts.idx_eq_pos) begin
               state_in = S_WRITE;
            end else begin
               ctl.idx_op = sdt_pkg::IDX_DEC;
               ctl.rd_sel = sdt_pkg::RD_IDX_M1;
            end
         end
         S_SHIFT_DN: begin
            ctl.wr_op = sdt_pkg::WR_DN;
            if (sts.idx_p1_at_last) begin
               ctl.occ_op = sdt_pkg::OCC_DEC;
               state_in   = S_FINISH;
            end else begin
               ctl.idx_op = sdt_pkg::IDX_INC;
               ctl.rd_sel = sdt_pkg::RD_IDX_P2;
            end
         end
         S_SEARCH: begin
            if (sts.key_eq_rd) begin
               ctl.load_found = 1'b1;
               state_in       = S_FINISH;
            end else if (sts.idx_at_last) begin
               ctl.set_status = 1'b1;
               ctl.status     = sdt_pkg::ST_MISS;
               state_in       = S_FINISH;
            end else begin
               ctl.idx_op = sdt_pkg::IDX_INC;
               ctl.rd_sel = sdt_pkg::RD_IDX_P1;
            end
         end
         S_WRITE: begin
            ctl.wr_op  = sdt_pkg::WR_ITEM;
            ctl.occ_op = sdt_pkg::OCC_INC;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: rtl/core/sorted_deque_table_top.sv
// Top level of the sorted deque table: stream ports, controller and datapath.
// Holds up to DEPTH (key, payload) entries in order in a single-port-read, single-port-write
// memory; one command is handled at a time. Scans and shifts sweep through the memory one
// entry a cycle, so pop front, search, push front and a sorted insert at the front or into
// the middle take longer the more entries are held, while pop back, push back and insert at
// the end do not. A finished result waits in an output register while the next word is
// accepted; a word that finishes while that register is still full waits in its last step
// until the earlier result is taken. Unused command codes return done with no change.
`default_nettype none
module sorted_deque_table_top #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [2:0] command, [34:3] key, [66:35] payload, [71:67] zero
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] status, [33:2] found_key, [65:34] found_payload, [70:66] entry_count, [71] zero
   output logic [71:0]      rsp_tdata
);

   sdt_pkg::ctl_cmd_type ctl;
   sdt_pkg::dp_sts_type  sts;

   logic [1:0]                     rsp_status;
   logic [sdt_pkg::KEY_W-1:0]      rsp_found_key;
   logic [sdt_pkg::PAY_W-1:0]      rsp_found_payload;
   logic [sdt_pkg::CNT_W-1:0]      rsp_entry_count;

   sdt_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   sdt_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .in_command        (req_tdata[2:0]),
      .in_key            (req_tdata[34:3]),
      .in_payload        (req_tdata[66:35]),
      .ctl               (ctl),
      .sts               (sts),
      .rsp_status        (rsp_status),
      .rsp_found_key     (rsp_found_key),
      .rsp_found_payload (rsp_found_payload),
      .rsp_entry_count   (rsp_entry_count)
   );

   assign rsp_tdata = {1'b0, rsp_entry_count, rsp_found_payload, rsp_found_key, rsp_status};

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("word accepted while another is in progress");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      (ctl.wr_op == sdt_pkg::WR_ITEM) |-> !sts.occ_full)
      else $error("entry written into a full table");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      (ctl.occ_op == sdt_pkg::OCC_DEC) |-> !sts.occ_zero)
      else $error("occupancy decremented below zero");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (!rsp_tvalid || rsp_tready))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

// File: tb/sorted_deque_table_top_tb.sv
// Self-checking testbench for the sorted deque table: directed, full, back-pressure, random.
`default_nettype none
module sorted_deque_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 64;

   // codes the block ignores
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   typedef struct {
      logic [1:0]        status;
      logic signed [31:0] found_key;
      logic [31:0]       found_payload;
      logic [4:0]        entry_count;
   } table_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   logic        hold_off   = 1'b0;
   event        hold_start;
   int          send_idle_pct = 10;
   int          recv_idle_pct = 67;
   int          error_count   = 0;
   int          cycle_count   = 0;

   // predictor state: the table as it should be after every accepted word
   logic signed [31:0] held_key [DEPTH];
   logic [31:0]        held_pay [DEPTH];
   int                 held_count = 0;
   table_result_type   pending_results[$];

   sorted_deque_table_top #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic predict_table_result(input logic [2:0] cmd, input logic signed [31:0] key,
                                       input logic [31:0] pay);
      table_result_type res;
      int slot;
      res.status        = sdt_pkg::ST_DONE;
      res.found_key     = '0;
      res.found_payload = '0;
      slot = -1;
      case (cmd)
         sdt_pkg::CMD_INSERT, sdt_pkg::CMD_PUSH_FRONT, sdt_pkg::CMD_PUSH_BACK: begin
            if (held_count >= DEPTH) begin
               res.status = sdt_pkg::ST_FULL;
            end else if (cmd == sdt_pkg::CMD_PUSH_FRONT) begin
               slot = 0;
            end else if (cmd == sdt_pkg::CMD_PUSH_BACK || held_count == 0) begin
               slot = held_count;
            end else if (key >= held_key[held_count-1]) begin
               slot = held_count;
            end else if (key <= held_key[0]) begin
               slot = 0;
            end else begin
               // scan starts after the front and stops at the back at the latest
               slot = 1;
               while (slot < held_count - 1 && held_key[slot] < key) slot++;
            end
            if (slot >= 0) begin
               for (int i = held_count; i > slot; i--) begin
                  held_key[i] = held_key[i-1];
                  held_pay[i] = held_pay[i-1];
               end
               held_key[slot] = key;
               held_pay[slot] = pay;
               held_count++;
            end
         end
         sdt_pkg::CMD_POP_FRONT, sdt_pkg::CMD_POP_BACK, sdt_pkg::CMD_SEARCH: begin
            if (held_count == 0) begin
               res.status = sdt_pkg::ST_EMPTY;
            end else if (cmd == sdt_pkg::CMD_POP_FRONT) begin
               for (int i = 0; i + 1 < held_count; i++) begin
                  held_key[i] = held_key[i+1];
                  held_pay[i] = held_pay[i+1];
               end
               held_count--;
            end else if (cmd == sdt_pkg::CMD_POP_BACK) begin
               held_count--;
            end else begin
               res.status = sdt_pkg::ST_MISS;
               for (int i = 0; i < held_count; i++) begin
                  if (held_key[i] == key) begin
                     res.status        = sdt_pkg::ST_DONE;
                     res.found_key     = held_key[i];
                     res.found_payload = held_pay[i];
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      res.entry_count = held_count[4:0];
      pending_results.push_back(res);
   endtask

   // entered and left at a falling edge
   task automatic send_word(input logic [2:0] cmd, input logic signed [31:0] key,
                            input logic [31:0] pay);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, pay, key, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_table_result(cmd, key, pay);
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_result_word(input logic [71:0] word);
      table_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected result word", word[31:0], '0);
      end else begin
         want = pending_results.pop_front();
         if (word[1:0] !== want.status)
            report_mismatch("status", word[1:0], want.status);
         if (word[33:2] !== want.found_key)
            report_mismatch("found_key", word[33:2], want.found_key);
         if (word[65:34] !== want.found_payload)
            report_mismatch("found_payload", word[65:34], want.found_payload);
         if (word[70:66] !== want.entry_count)
            report_mismatch("entry_count", word[70:66], want.entry_count);
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result_word(rsp_tdata);
   end

   // long receiver hold-off, timed on its own
   always begin
      @(hold_start);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off = 1'b0;
   end

   function automatic logic signed [31:0] pick_key();
      logic signed [31:0] k;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: k = $signed($urandom_range(16)) - 8;
         5, 6: k = $urandom;
         7: begin
            case ($urandom_range(3))
               0: k = KEY_MIN;
               1: k = KEY_MAX;
               2: k = 0;
               default: k = -1;
            endcase
         end
         default: k = (held_count > 0) ? held_key[$urandom_range(held_count-1)] : $urandom;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] pick_command(input int mode);
      int r;
      int ins_pct;
      int srch_pct;
      r = $urandom_range(99);
      case (mode)
         MODE_FILL:  begin ins_pct = 70; srch_pct = 15; end
         MODE_DRAIN: begin ins_pct = 15; srch_pct = 20; end
         default:    begin ins_pct = 40; srch_pct = 20; end
      endcase
      if (r < ins_pct) begin
         case ($urandom_range(3))
            0, 1: return sdt_pkg::CMD_INSERT;
            2: return sdt_pkg::CMD_PUSH_FRONT;
            default: return sdt_pkg::CMD_PUSH_BACK;
         endcase
      end else if (r < ins_pct + srch_pct) begin
         return sdt_pkg::CMD_SEARCH;
      end
      return $urandom_range(1) ? sdt_pkg::CMD_POP_FRONT : sdt_pkg::CMD_POP_BACK;
   endfunction

   task automatic test_directed_cases();
      // empty table: removes and search are no-ops, spare codes are ignored; then sorted inserts
      send_word(sdt_pkg::CMD_POP_FRONT, 0, 0);
      send_word(sdt_pkg::CMD_POP_BACK, 0, 0);
      send_word(sdt_pkg::CMD_SEARCH, 1, 0);
      send_word(CMD_SPARE_6, KEY_MAX, 32'hffff_ffff);
      send_word(CMD_SPARE_7, KEY_MIN, 32'hffff_ffff);
      send_word(sdt_pkg::CMD_INSERT, 0, 32'hffff_ffff);
      send_word(sdt_pkg::CMD_INSERT, KEY_MAX, 32'h0000_0000);
      send_word(sdt_pkg::CMD_INSERT, KEY_MIN, 32'h5555_5555);
      send_word(sdt_pkg::CMD_INSERT, 5, 32'haaaa_aaaa);
      send_word(sdt_pkg::CMD_INSERT, 5, 32'h1234_5678);
      // break the ordering, then sorted inserts, searches and pops on an unsorted list
      send_word(sdt_pkg::CMD_PUSH_FRONT, 100, 32'h0000_0100);
      send_word(sdt_pkg::CMD_PUSH_BACK, -7, 32'h0000_0007);
      send_word(sdt_pkg::CMD_INSERT, 50, 32'h0000_0050);
      send_word(sdt_pkg::CMD_INSERT, -100, 32'h0000_1000);
      send_word(sdt_pkg::CMD_INSERT, 3, 32'h0000_0003);
      send_word(sdt_pkg::CMD_SEARCH, 5, 0);
      send_word(sdt_pkg::CMD_SEARCH, 12345, 0);
      send_word(sdt_pkg::CMD_SEARCH, KEY_MIN, 0);
      send_word(sdt_pkg::CMD_SEARCH, KEY_MAX, 0);
      send_word(sdt_pkg::CMD_POP_FRONT, 0, 0);
      send_word(sdt_pkg::CMD_POP_BACK, 0, 0);
      send_word(CMD_SPARE_7, 1, 1);
      send_word(sdt_pkg::CMD_SEARCH, -7, 0);
   endtask

   task automatic test_list_full();
      while (held_count < DEPTH) send_word(sdt_pkg::CMD_INSERT, pick_key(), $urandom);
      send_word(sdt_pkg::CMD_INSERT, 0, $urandom);
      send_word(sdt_pkg::CMD_PUSH_FRONT, KEY_MIN, $urandom);
      send_word(sdt_pkg::CMD_PUSH_BACK, KEY_MAX, $urandom);
      send_word(sdt_pkg::CMD_SEARCH, held_key[DEPTH-1], 0);
      while (held_count > 0)
         send_word($urandom_range(1) ? sdt_pkg::CMD_POP_FRONT : sdt_pkg::CMD_POP_BACK, 0, 0);
      send_word(sdt_pkg::CMD_POP_BACK, 0, 0);
      send_word(sdt_pkg::CMD_SEARCH, 0, 0);
   endtask

   task automatic test_backpressure();
      -> hold_start;
      repeat (24) send_word(pick_command(MODE_FILL), pick_key(), $urandom);
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct, input int n_words);
      int sent;
      int mode;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      mode = MODE_FILL;
      while (sent < n_words) begin
         if (sent % 30 == 0) mode = $urandom_range(2);
         if ($urandom_range(99) < 3) begin
            send_word($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7, $urandom, $urandom);
         end else begin
            send_word(pick_command(mode), pick_key(), $urandom);
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(10, 67, 120);
      run_random_phase(67, 10, 120);
      run_random_phase(0, 0, 120);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_list_full();
      test_backpressure();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: sorted_deque_table_top.f
rtl/core/sdt_pkg.sv
rtl/core/sdt_datapath.sv
rtl/core/sdt_controller.sv
rtl/core/sorted_deque_table_top.sv
tb/sorted_deque_table_top_tb.sv
